@@ rtl/ecbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ecbp_pkg
// Shared widths, constants, codes and the controller command bundle for the
// encoder click and button pulser.
// ----------------------------------------------------------------------------
package ecbp_pkg;

  localparam int ENC_DEFAULT  = 4;
  localparam int ENC_MAX      = 8;
  localparam int PORT_ENC     = 4;

  localparam int DELTA_W      = 8;
  localparam int ACC_W        = 10;
  localparam int MAG_W        = 9;
  localparam int STEP_W       = 8;
  localparam int LEVEL_W      = 7;
  localparam int QUICK_W      = 9;
  localparam int TIME_W       = 32;
  localparam int MASK_W       = 8;
  localparam int MODE_W       = 2;
  localparam int SW_W         = 4;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  localparam int LEVEL_MAX    = 100;
  localparam int HOLD_MIN     = 30;
  localparam int HOLD_DEFAULT = 80;
  localparam int PULSE_MIN    = 5;
  localparam int QUICK_LIMIT  = 128;

  localparam int DIV_STEPS    = MAG_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [SW_W-1:0]       INVERT_RESET = '0;
  localparam logic [CFG_DATA_W-1:0] STEPS_RESET  = 32'h0101_0101;
  localparam logic [2*SW_W-1:0]     MODE_RESET   = '0;
  localparam logic [CFG_DATA_W-1:0] PULSE_RESET  = 32'h3232_3232;

  typedef enum logic [MODE_W-1:0] {
    MODE_PULSE     = 2'd0,
    MODE_HOLD      = 2'd1,
    MODE_ABS       = 2'd2,
    MODE_PULSE_ALT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT = 8'd0,
    REG_STEPS  = 8'd1,
    REG_MODE   = 8'd2,
    REG_PULSE  = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
    logic finish;
  } ecbp_cmd_t;

endpackage

@@ rtl/encoder_click_button_pulser.sv @@
// ----------------------------------------------------------------------------
// encoder_click_button_pulser
// Turns encoder delta reports into clicks, absolute levels, quick-menu steps
// and cw/ccw button pulses.
//
// Channels: in_* carries one report per beat (four deltas, switch bits,
// millisecond time); out_* carries one result beat per report (button mask,
// four levels, four quick-menu counts); cfg_* writes registers 0..3
// (invert mask, steps per click, mode codes, pulse length), always ready,
// other indexes ignored. Write config only while no report is in flight.
// Reports are taken one at a time: the next report is accepted only after
// the previous one has run through the bit-serial click divider, 9 steps,
// run in all encoder lanes at once, and then the apply and expiry states.
// Reset clears accumulators, levels, deadlines and restores register
// defaults; no clearing pass is needed. A stalled result sits in the output
// register; the next report is accepted meanwhile and waits in the expiry
// step until the output register frees up.
// ----------------------------------------------------------------------------
module encoder_click_button_pulser #(
  parameter int ENCODER_COUNT = ecbp_pkg::ENC_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ecbp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ecbp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_zero,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_one,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_two,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_three,
  input  logic [ecbp_pkg::SW_W-1:0]              in_switch_bits,
  input  logic [ecbp_pkg::TIME_W-1:0]            in_now_ms,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ecbp_pkg::MASK_W-1:0]            out_button_mask,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_zero,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_one,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_two,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_three,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_zero,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_one,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_two,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_three
);

  ecbp_pkg::ecbp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ecbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ecbp_datapath #(
    .ENCODER_COUNT (ENCODER_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_delta_zero   (in_delta_zero),
    .in_delta_one    (in_delta_one),
    .in_delta_two    (in_delta_two),
    .in_delta_three  (in_delta_three),
    .in_switch_bits  (in_switch_bits),
    .in_now_ms       (in_now_ms),
    .out_button_mask (out_button_mask),
    .out_level_zero  (out_level_zero),
    .out_level_one   (out_level_one),
    .out_level_two   (out_level_two),
    .out_level_three (out_level_three),
    .out_quick_zero  (out_quick_zero),
    .out_quick_one   (out_quick_one),
    .out_quick_two   (out_quick_two),
    .out_quick_three (out_quick_three)
  );

endmodule

@@ rtl/ecbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ecbp_ctrl
// Sequencer: accepts a beat, runs the click divider, applies the clicks,
// then expires deadlines into the output register.
// ----------------------------------------------------------------------------
module ecbp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ecbp_pkg::ecbp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_EXPIRE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [ecbp_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.step   = (state_r == ST_DIV);
    cmd.apply  = (state_r == ST_APPLY);
    cmd.finish = (state_r == ST_EXPIRE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        if (cnt_r == ecbp_pkg::DIV_CNT_W'(ecbp_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_APPLY: begin
        state_nxt = ST_EXPIRE;
      end
      ST_EXPIRE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/ecbp_datapath.sv @@
// ----------------------------------------------------------------------------
// ecbp_datapath
// Configuration registers, one lane per encoder (accumulator, bit-serial
// click divider, level and two button deadlines) and the output register.
// ----------------------------------------------------------------------------
module ecbp_datapath #(
  parameter int ENCODER_COUNT = ecbp_pkg::ENC_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ecbp_pkg::ecbp_cmd_t                    cmd,
  input  logic                                   cfg_valid,
  input  logic [ecbp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ecbp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_zero,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_one,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_two,
  input  logic signed [ecbp_pkg::DELTA_W-1:0]    in_delta_three,
  input  logic [ecbp_pkg::SW_W-1:0]              in_switch_bits,
  input  logic [ecbp_pkg::TIME_W-1:0]            in_now_ms,
  output logic [ecbp_pkg::MASK_W-1:0]            out_button_mask,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_zero,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_one,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_two,
  output logic [ecbp_pkg::LEVEL_W-1:0]           out_level_three,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_zero,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_one,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_two,
  output logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_three
);

  localparam int EM = ecbp_pkg::ENC_MAX;
  localparam int PE = ecbp_pkg::PORT_ENC;

  logic [ecbp_pkg::SW_W-1:0]       inv_r;
  logic [ecbp_pkg::CFG_DATA_W-1:0] steps_r;
  logic [2*ecbp_pkg::SW_W-1:0]     mode_r;
  logic [ecbp_pkg::CFG_DATA_W-1:0] plen_r;
  logic [ecbp_pkg::TIME_W-1:0]     now_r;

  logic [EM-1:0]                   inv_ext;
  logic [EM-1:0]                   sw_ext;
  logic [EM*ecbp_pkg::STEP_W-1:0]  steps_ext;
  logic [EM*ecbp_pkg::STEP_W-1:0]  plen_ext;
  logic [EM*ecbp_pkg::MODE_W-1:0]  mode_ext;
  logic signed [ecbp_pkg::DELTA_W-1:0] delta_a [EM];

  logic [2*ENCODER_COUNT-1:0]               act_w;
  logic [2*ENCODER_COUNT+ecbp_pkg::MASK_W-1:0] act_pad;
  logic [ecbp_pkg::LEVEL_W-1:0]             level_w [ENCODER_COUNT];
  logic signed [ecbp_pkg::QUICK_W-1:0]      quick_w [ENCODER_COUNT];
  logic [ecbp_pkg::LEVEL_W-1:0]             level_p [PE];
  logic signed [ecbp_pkg::QUICK_W-1:0]      quick_p [PE];

  logic [ecbp_pkg::MASK_W-1:0]              mask_r;
  logic [ecbp_pkg::LEVEL_W-1:0]             olevel_r [PE];
  logic signed [ecbp_pkg::QUICK_W-1:0]      oquick_r [PE];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r   <= ecbp_pkg::INVERT_RESET;
      steps_r <= ecbp_pkg::STEPS_RESET;
      mode_r  <= ecbp_pkg::MODE_RESET;
      plen_r  <= ecbp_pkg::PULSE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ecbp_pkg::REG_INVERT: inv_r   <= cfg_data[ecbp_pkg::SW_W-1:0];
        ecbp_pkg::REG_STEPS:  steps_r <= cfg_data;
        ecbp_pkg::REG_MODE:   mode_r  <= cfg_data[2*ecbp_pkg::SW_W-1:0];
        ecbp_pkg::REG_PULSE:  plen_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_now_ms;
    end
  end

  assign inv_ext   = EM'(inv_r);
  assign sw_ext    = EM'(in_switch_bits);
  assign steps_ext = (EM*ecbp_pkg::STEP_W)'(steps_r);
  assign plen_ext  = (EM*ecbp_pkg::STEP_W)'(plen_r);
  assign mode_ext  = (EM*ecbp_pkg::MODE_W)'(mode_r);

  always_comb begin
    for (int k = 0; k < EM; k++) begin
      delta_a[k] = '0;
    end
    delta_a[0] = in_delta_zero;
    delta_a[1] = in_delta_one;
    delta_a[2] = in_delta_two;
    delta_a[3] = in_delta_three;
  end

  for (genvar i = 0; i < ENCODER_COUNT; i++) begin : g_lane
    logic signed [ecbp_pkg::DELTA_W:0]   dext_w;
    logic signed [ecbp_pkg::DELTA_W:0]   d_w;
    logic signed [ecbp_pkg::ACC_W-1:0]   sum_w;
    logic [ecbp_pkg::ACC_W-1:0]          abs_w;
    logic [ecbp_pkg::STEP_W-1:0]         sbyte_w;
    logic [ecbp_pkg::STEP_W-1:0]         len_w;
    logic [ecbp_pkg::STEP_W-1:0]         hold_w;
    logic [ecbp_pkg::STEP_W-1:0]         plen_w;
    ecbp_pkg::mode_t                     mode_w;

    logic [ecbp_pkg::MAG_W-1:0]          trial_w;
    logic                                ge_w;
    logic [ecbp_pkg::MAG_W-1:0]          diff_w;

    logic signed [ecbp_pkg::ACC_W-1:0]   clicks_w;
    logic signed [ecbp_pkg::ACC_W-1:0]   rems_w;
    logic signed [ecbp_pkg::ACC_W:0]     lvsum_w;
    logic [ecbp_pkg::LEVEL_W-1:0]        lvclamp_w;
    logic signed [ecbp_pkg::QUICK_W-1:0] qsat_w;
    logic [ecbp_pkg::TIME_W-1:0]         hold_dl_w;
    logic [ecbp_pkg::TIME_W-1:0]         pulse_dl_w;
    logic [ecbp_pkg::TIME_W-1:0]         cw_age_w;
    logic [ecbp_pkg::TIME_W-1:0]         ccw_age_w;
    logic                                cw_act_w;
    logic                                ccw_act_w;
    logic                                pos_w;

    logic signed [ecbp_pkg::ACC_W-1:0]   acc_r;
    logic [ecbp_pkg::LEVEL_W-1:0]        level_r;
    logic [ecbp_pkg::TIME_W-1:0]         cw_r;
    logic [ecbp_pkg::TIME_W-1:0]         ccw_r;
    logic                                act_r;
    logic                                neg_r;
    logic                                sw_r;
    logic [ecbp_pkg::MAG_W-1:0]          q_r;
    logic [ecbp_pkg::STEP_W-1:0]         rem_r;
    logic [ecbp_pkg::STEP_W-1:0]         div_r;
    logic signed [ecbp_pkg::QUICK_W-1:0] quick_r;

    // load: invert, accumulate, split into sign and magnitude
    assign dext_w  = ecbp_pkg::DELTA_W'(delta_a[i]);
    assign d_w     = inv_ext[i] ? -dext_w : dext_w;
    assign sum_w   = acc_r + ecbp_pkg::ACC_W'(d_w);
    assign abs_w   = sum_w[ecbp_pkg::ACC_W-1] ? ecbp_pkg::ACC_W'(-sum_w) : sum_w;
    assign sbyte_w = steps_ext[i*ecbp_pkg::STEP_W +: ecbp_pkg::STEP_W];

    // restoring divider, one quotient bit per step
    assign trial_w = {rem_r, q_r[ecbp_pkg::MAG_W-1]};
    assign ge_w    = trial_w >= {1'b0, div_r};
    assign diff_w  = trial_w - {1'b0, div_r};

    // apply
    assign clicks_w = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    assign rems_w   = neg_r ? -$signed(ecbp_pkg::ACC_W'(rem_r))
                            : $signed(ecbp_pkg::ACC_W'(rem_r));
    assign pos_w    = !clicks_w[ecbp_pkg::ACC_W-1];
    assign lvsum_w  = $signed({4'b0, level_r}) + ecbp_pkg::ACC_W'(clicks_w);

    always_comb begin
      if (lvsum_w < 0) begin
        lvclamp_w = '0;
      end else if (lvsum_w > ecbp_pkg::LEVEL_MAX) begin
        lvclamp_w = ecbp_pkg::LEVEL_W'(ecbp_pkg::LEVEL_MAX);
      end else begin
        lvclamp_w = lvsum_w[ecbp_pkg::LEVEL_W-1:0];
      end
    end

    always_comb begin
      if (clicks_w > ecbp_pkg::QUICK_LIMIT) begin
        qsat_w = ecbp_pkg::QUICK_W'(ecbp_pkg::QUICK_LIMIT);
      end else if (clicks_w < -ecbp_pkg::QUICK_LIMIT) begin
        qsat_w = ecbp_pkg::QUICK_W'(-ecbp_pkg::QUICK_LIMIT);
      end else begin
        qsat_w = clicks_w[ecbp_pkg::QUICK_W-1:0];
      end
    end

    assign mode_w     = ecbp_pkg::mode_t'(mode_ext[i*ecbp_pkg::MODE_W +: ecbp_pkg::MODE_W]);
    assign len_w      = plen_ext[i*ecbp_pkg::STEP_W +: ecbp_pkg::STEP_W];
    assign hold_w     = (len_w < ecbp_pkg::HOLD_MIN) ?
                        ecbp_pkg::STEP_W'(ecbp_pkg::HOLD_DEFAULT) : len_w;
    assign plen_w     = (len_w < ecbp_pkg::PULSE_MIN) ?
                        ecbp_pkg::STEP_W'(ecbp_pkg::PULSE_MIN) : len_w;
    assign hold_dl_w  = now_r + ecbp_pkg::TIME_W'(hold_w);
    assign pulse_dl_w = now_r + ecbp_pkg::TIME_W'(plen_w);

    // expiry
    assign cw_age_w  = now_r - cw_r;
    assign ccw_age_w = now_r - ccw_r;
    assign cw_act_w  = (cw_r != '0) && cw_age_w[ecbp_pkg::TIME_W-1];
    assign ccw_act_w = (ccw_r != '0) && ccw_age_w[ecbp_pkg::TIME_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r   <= '0;
        level_r <= '0;
        cw_r    <= '0;
        ccw_r   <= '0;
      end else if (cmd.apply && act_r) begin
        acc_r <= rems_w;
        if (!sw_r && (clicks_w != '0)) begin
          case (mode_w)
            ecbp_pkg::MODE_ABS: begin
              level_r <= lvclamp_w;
            end
            ecbp_pkg::MODE_HOLD: begin
              if (pos_w) begin
                cw_r  <= hold_dl_w;
                ccw_r <= '0;
              end else begin
                ccw_r <= hold_dl_w;
                cw_r  <= '0;
              end
            end
            default: begin
              if (pos_w) begin
                if (pulse_dl_w > cw_r) begin
                  cw_r <= pulse_dl_w;
                end
              end else begin
                if (pulse_dl_w > ccw_r) begin
                  ccw_r <= pulse_dl_w;
                end
              end
            end
          endcase
        end
      end else if (cmd.finish) begin
        cw_r  <= cw_act_w ? cw_r : '0;
        ccw_r <= ccw_act_w ? ccw_r : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        act_r <= (d_w != '0);
        neg_r <= sum_w[ecbp_pkg::ACC_W-1];
        sw_r  <= sw_ext[i];
        q_r   <= abs_w[ecbp_pkg::MAG_W-1:0];
        rem_r <= '0;
        div_r <= (sbyte_w == '0) ? ecbp_pkg::STEP_W'(1) : sbyte_w;
      end else if (cmd.step) begin
        q_r   <= {q_r[ecbp_pkg::MAG_W-2:0], ge_w};
        rem_r <= ge_w ? diff_w[ecbp_pkg::STEP_W-1:0] : trial_w[ecbp_pkg::STEP_W-1:0];
      end
      if (cmd.apply) begin
        quick_r <= (act_r && sw_r) ? qsat_w : '0;
      end
    end

    assign act_w[i]               = cw_act_w;
    assign act_w[ENCODER_COUNT+i] = ccw_act_w;
    assign level_w[i]             = level_r;
    assign quick_w[i]             = quick_r;
  end

  assign act_pad = {{ecbp_pkg::MASK_W{1'b0}}, act_w};

  for (genvar j = 0; j < PE; j++) begin : g_port
    if (j < ENCODER_COUNT) begin : g_used
      assign level_p[j] = level_w[j];
      assign quick_p[j] = quick_w[j];
    end else begin : g_unused
      assign level_p[j] = '0;
      assign quick_p[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mask_r <= act_pad[ecbp_pkg::MASK_W-1:0];
      for (int k = 0; k < PE; k++) begin
        olevel_r[k] <= level_p[k];
        oquick_r[k] <= quick_p[k];
      end
    end
  end

  assign out_button_mask = mask_r;
  assign out_level_zero  = olevel_r[0];
  assign out_level_one   = olevel_r[1];
  assign out_level_two   = olevel_r[2];
  assign out_level_three = olevel_r[3];
  assign out_quick_zero  = oquick_r[0];
  assign out_quick_one   = oquick_r[1];
  assign out_quick_two   = oquick_r[2];
  assign out_quick_three = oquick_r[3];

endmodule

@@ rtl/ecbp_checker.sv @@
// ----------------------------------------------------------------------------
// ecbp_checker
// Port-level checks for the encoder click and button pulser, bound to the
// top level.
// ----------------------------------------------------------------------------
module ecbp_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [ecbp_pkg::MASK_W-1:0]            out_button_mask,
  input  logic [ecbp_pkg::LEVEL_W-1:0]           out_level_zero,
  input  logic [ecbp_pkg::LEVEL_W-1:0]           out_level_one,
  input  logic [ecbp_pkg::LEVEL_W-1:0]           out_level_two,
  input  logic [ecbp_pkg::LEVEL_W-1:0]           out_level_three,
  input  logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_zero,
  input  logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_one,
  input  logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_two,
  input  logic signed [ecbp_pkg::QUICK_W-1:0]    out_quick_three
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_button_mask)
      && $stable(out_level_zero) && $stable(out_quick_zero))
    else $error("stalled result beat changed");

  // busy after accepting a report
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("report accepted while busy");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_zero <= 7'd100 && out_level_one <= 7'd100
      && out_level_two <= 7'd100 && out_level_three <= 7'd100)
    else $error("level out of range");

  a_quick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quick_zero >= -9'sd128 && out_quick_zero <= 9'sd128
      && out_quick_one >= -9'sd128 && out_quick_one <= 9'sd128
      && out_quick_two >= -9'sd128 && out_quick_two <= 9'sd128
      && out_quick_three >= -9'sd128 && out_quick_three <= 9'sd128)
    else $error("quick-menu count out of range");

endmodule

bind encoder_click_button_pulser ecbp_checker u_ecbp_checker (.*);

@@ bench/encoder_click_button_pulser_tb.sv @@
// ----------------------------------------------------------------------------
// encoder_click_button_pulser_tb
// Self-checking bench for the encoder click and button pulser. Reports go in
// over a valid/ready channel while a scoreboard class tracks the accumulators,
// levels and button deadlines and predicts each result beat, which is then
// compared field by field. A short directed run covers the corner cases, then
// six register settings each get a stretch of random reports under varying
// sender and receiver idling, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module encoder_click_button_pulser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecbp_pkg::*;

  localparam int REG_COUNT    = 4;
  localparam int STALL_CYCLES = 100;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 130;

  typedef struct packed {
    logic [PORT_ENC-1:0][DELTA_W-1:0] delta;
    logic [SW_W-1:0]                  switches;
    logic [TIME_W-1:0]                now;
  } report_t;

  typedef struct packed {
    logic [MASK_W-1:0]                buttons;
    logic [PORT_ENC-1:0][LEVEL_W-1:0] level;
    logic [PORT_ENC-1:0][QUICK_W-1:0] quick;
  } result_t;

  class click_scoreboard;
    logic [SW_W-1:0]       invert_bits;
    logic [CFG_DATA_W-1:0] step_bytes;
    logic [2*SW_W-1:0]     mode_bits;
    logic [CFG_DATA_W-1:0] length_bytes;
    int                    remainder [PORT_ENC];
    int                    level [PORT_ENC];
    logic [TIME_W-1:0]     deadline [2*PORT_ENC];
    result_t               expected_q [$];
    int                    errors;

    function new();
      invert_bits  = INVERT_RESET;
      step_bytes   = STEPS_RESET;
      mode_bits    = MODE_RESET;
      length_bytes = PULSE_RESET;
      foreach (remainder[i]) begin
        remainder[i] = 0;
        level[i]     = 0;
      end
      foreach (deadline[i]) deadline[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INVERT: invert_bits  = data[SW_W-1:0];
        REG_STEPS:  step_bytes   = data;
        REG_MODE:   mode_bits    = data[2*SW_W-1:0];
        REG_PULSE:  length_bytes = data;
        default: ;
      endcase
    endfunction

    function void note_report(report_t r);
      result_t           e;
      int                d;
      int                steps;
      int                sum;
      int                clicks;
      int                own;
      int                opp;
      logic [TIME_W-1:0] len;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] gap;
      e = '0;
      for (int i = 0; i < PORT_ENC; i++) begin
        d = $signed(r.delta[i]);
        if (d == 0) continue;
        if (invert_bits[i]) d = -d;
        steps = int'(step_bytes[STEP_W*i +: STEP_W]);
        if (steps < 1) steps = 1;
        sum          = remainder[i] + d;
        clicks       = sum / steps;
        remainder[i] = sum - clicks * steps;
        if (r.switches[i]) begin
          if (clicks > QUICK_LIMIT) clicks = QUICK_LIMIT;
          if (clicks < -QUICK_LIMIT) clicks = -QUICK_LIMIT;
          e.quick[i] = QUICK_W'(clicks);
          continue;
        end
        if (clicks == 0) continue;
        len = TIME_W'(length_bytes[STEP_W*i +: STEP_W]);
        own = (clicks > 0) ? i : PORT_ENC + i;
        opp = (clicks > 0) ? PORT_ENC + i : i;
        case (mode_t'(mode_bits[MODE_W*i +: MODE_W]))
          MODE_ABS: begin
            level[i] = level[i] + clicks;
            if (level[i] < 0) level[i] = 0;
            if (level[i] > LEVEL_MAX) level[i] = LEVEL_MAX;
          end
          MODE_HOLD: begin
            span = (len < HOLD_MIN) ? TIME_W'(HOLD_DEFAULT) : len;
            deadline[opp] = '0;
            deadline[own] = r.now + span;
          end
          default: begin
            span = (len < PULSE_MIN) ? TIME_W'(PULSE_MIN) : len;
            if (r.now + span > deadline[own]) deadline[own] = r.now + span;
          end
        endcase
      end
      for (int j = 0; j < 2 * PORT_ENC; j++) begin
        gap = r.now - deadline[j];
        if (deadline[j] != '0 && gap[TIME_W-1]) e.buttons[j] = 1'b1;
        else deadline[j] = '0;
      end
      foreach (level[i]) e.level[i] = LEVEL_W'(level[i]);
      expected_q.push_back(e);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with no report pending, expected none got mask %0h",
                 $time, got.buttons);
        return;
      end
      want = expected_q.pop_front();
      compare("button_mask", want.buttons, got.buttons);
      for (int i = 0; i < PORT_ENC; i++) begin
        compare($sformatf("level%0d", i), want.level[i], got.level[i]);
        compare($sformatf("quick%0d", i), want.quick[i], got.quick[i]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [DELTA_W-1:0] in_delta_zero;
  logic signed [DELTA_W-1:0] in_delta_one;
  logic signed [DELTA_W-1:0] in_delta_two;
  logic signed [DELTA_W-1:0] in_delta_three;
  logic [SW_W-1:0]           in_switch_bits;
  logic [TIME_W-1:0]         in_now_ms;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [MASK_W-1:0]         out_button_mask;
  logic [LEVEL_W-1:0]        out_level_zero;
  logic [LEVEL_W-1:0]        out_level_one;
  logic [LEVEL_W-1:0]        out_level_two;
  logic [LEVEL_W-1:0]        out_level_three;
  logic signed [QUICK_W-1:0] out_quick_zero;
  logic signed [QUICK_W-1:0] out_quick_one;
  logic signed [QUICK_W-1:0] out_quick_two;
  logic signed [QUICK_W-1:0] out_quick_three;

  click_scoreboard   sb;
  result_t           beat;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                stall_asked   = 0;
  int                stall_served  = 0;
  int                stall_left    = 0;
  int                quiet_cycles  = 0;
  logic [TIME_W-1:0] clock_ms      = '0;

  encoder_click_button_pulser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_delta_zero   (in_delta_zero),
    .in_delta_one    (in_delta_one),
    .in_delta_two    (in_delta_two),
    .in_delta_three  (in_delta_three),
    .in_switch_bits  (in_switch_bits),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_button_mask (out_button_mask),
    .out_level_zero  (out_level_zero),
    .out_level_one   (out_level_one),
    .out_level_two   (out_level_two),
    .out_level_three (out_level_three),
    .out_quick_zero  (out_quick_zero),
    .out_quick_one   (out_quick_one),
    .out_quick_two   (out_quick_two),
    .out_quick_three (out_quick_three)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random idling plus requested long hold-offs
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_asked) begin
      out_ready    <= 1'b0;
      stall_served <= stall_asked;
      stall_left   <= STALL_CYCLES;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beat.buttons  = out_button_mask;
      beat.level[0] = out_level_zero;
      beat.level[1] = out_level_one;
      beat.level[2] = out_level_two;
      beat.level[3] = out_level_three;
      beat.quick[0] = out_quick_zero;
      beat.quick[1] = out_quick_one;
      beat.quick[2] = out_quick_two;
      beat.quick[3] = out_quick_three;
      sb.check_result(beat);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("encoder_click_button_pulser_tb: FAIL");
    $finish;
  end

  function automatic report_t make_report(int d0, int d1, int d2, int d3,
                                          logic [SW_W-1:0] sw, logic [TIME_W-1:0] now);
    report_t r;
    r.delta[0] = DELTA_W'(d0);
    r.delta[1] = DELTA_W'(d1);
    r.delta[2] = DELTA_W'(d2);
    r.delta[3] = DELTA_W'(d3);
    r.switches = sw;
    r.now      = now;
    return r;
  endfunction

  function automatic report_t random_report();
    report_t r;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, 40);
    r.now = clock_ms;
    for (int i = 0; i < PORT_ENC; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) r.delta[i] = '0;
      else if (pick < 75) r.delta[i] = DELTA_W'($urandom_range(0, 8) - 4);
      else r.delta[i] = DELTA_W'($urandom());
      r.switches[i] = ($urandom_range(0, 3) == 0);
    end
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] small_steps(int top);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < PORT_ENC; i++) v[STEP_W*i +: STEP_W] = STEP_W'($urandom_range(0, top));
    return v;
  endfunction

  task automatic send_report(report_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_delta_three, in_delta_two, in_delta_one, in_delta_zero} <= r.delta;
    in_switch_bits <= r.switches;
    in_now_ms      <= r.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_report(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // a stray write to an unused index goes first, then the four registers
  task automatic load_settings(logic [SW_W-1:0] inv, logic [CFG_DATA_W-1:0] steps,
                               logic [2*SW_W-1:0] modes, logic [CFG_DATA_W-1:0] lens);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx[0] = CFG_IDX_W'(REG_COUNT + $urandom_range(0, 251));
    val[0] = $urandom();
    idx[1] = REG_INVERT;
    val[1] = {28'($urandom()), inv};
    idx[2] = REG_STEPS;
    val[2] = steps;
    idx[3] = REG_MODE;
    val[3] = {24'($urandom()), modes};
    idx[4] = REG_PULSE;
    val[4] = lens;
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_delta_zero  = '0;
    in_delta_one   = '0;
    in_delta_two   = '0;
    in_delta_three = '0;
    in_switch_bits = '0;
    in_now_ms      = '0;
    send_idle_pct  = 36;
    recv_idle_pct  = 73;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: pulses, expiry edge, quick-menu extremes
    send_report(make_report(0, 0, 0, 0, 4'h0, 1000));
    send_report(make_report(127, -128, 1, -1, 4'h0, 1000));
    send_report(make_report(0, 0, 0, 0, 4'h0, 1049));
    send_report(make_report(0, 0, 0, 0, 4'h0, 1050));
    send_report(make_report(1, -1, 0, 0, 4'hF, 1060));
    send_report(make_report(127, -128, 127, -128, 4'hF, 1070));
    wait_drained();

    // one encoder per mode, inverted -128, short lengths, saturating levels
    load_settings(4'h1, 32'hFF03_0200, 8'hE4, 32'hFF40_0A02);
    send_report(make_report(-128, 3, 100, -128, 4'h1, 2000));
    send_report(make_report(127, -4, 127, -128, 4'h0, 2001));
    send_report(make_report(0, 0, 127, 0, 4'h0, 2002));
    send_report(make_report(0, 0, -128, 0, 4'h0, 2003));
    send_report(make_report(0, 0, -128, 0, 4'h0, 2004));
    send_report(make_report(0, 0, -128, 0, 4'h0, 2005));
    send_report(make_report(0, 0, 0, 127, 4'h0, 3000));
    send_report(make_report(0, 0, 0, 127, 4'h0, 3001));
    send_report(make_report(0, 0, 0, 127, 4'h0, 2900));
    send_report(make_report(0, 0, 0, 127, 4'h0, 2800));
    send_report(make_report(-1, 0, 0, 0, 4'h0, 32'hFFFF_FFFB));
    send_report(make_report(0, 2, 0, 0, 4'h0, 32'hFFFF_FFB0));
    wait_drained();

    // build up remainders, then drop to one count per click
    load_settings(4'h0, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000);
    send_report(make_report(127, -128, 127, 0, 4'h0, 100));
    send_report(make_report(127, -126, 0, 0, 4'h0, 101));
    wait_drained();
    load_settings(4'h0, 32'h0000_0000, 8'h00, 32'h0000_0000);
    send_report(make_report(127, -128, 0, 0, 4'h3, 102));
    send_report(make_report(0, 0, 5, 0, 4'h0, 103));

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      send_idle_pct = (p < 2) ? 36 : (p < 4) ? 73 : 0;
      recv_idle_pct = (p < 2) ? 73 : (p < 4) ? 36 : 0;
      clock_ms      = $urandom();
      case (p)
        0: load_settings(4'hF, 32'h0403_0201, 8'hE4, 32'h1E1D_0504);
        1: load_settings(4'h0, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF);
        2: load_settings(4'h5, 32'hFFFF_FFFF, 8'h55, 32'h0000_0000);
        3: load_settings(4'hA, small_steps(8), 8'hAA, $urandom());
        4: load_settings(SW_W'($urandom()), $urandom(), 8'($urandom()), $urandom());
        default: load_settings(SW_W'($urandom()), small_steps(4), 8'($urandom()), $urandom());
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 30) stall_asked <= stall_asked + 1;
        if (n == 80) wait_drained();
        send_report(random_report());
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("encoder_click_button_pulser_tb: PASS");
    else
      $display("encoder_click_button_pulser_tb: FAIL");
    $finish;
  end

endmodule
